@@ hw/rtl/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types and constants for the indexed list block: command and status
// codes, the cell operation word and the controller states.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FIDX_W    = 4;
  localparam int unsigned LEN_W     = 5;
  // index width that covers the largest supported list depth
  localparam int unsigned IDX_W_MAX = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_DISPLAY   = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 3'd0,
    STS_EMPTY  = 3'd1,
    STS_BADIDX = 3'd2,
    STS_FULL   = 3'd3,
    STS_NOFIND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e                 cmd;
    logic [IDX_W_MAX-1:0]      pos;
    logic [IDX_W_MAX-1:0]      wrap;
    logic signed [DATA_W-1:0]  value;
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

@@ hw/rtl/indexed_list_insert_delete_search_top.sv @@
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search_top
// Ordered list of signed words held in a row of shifting cells, with insert,
// delete, search and display commands.
// ----------------------------------------------------------------------------
// Insert and delete: the registered result follows in the cycle after
//   acceptance, one command per cycle while the result side keeps up.
// Search and display: the cell row rotates once, one cell per cycle while
//   the result side keeps up; display emits one word per cell, search a single
//   word at the end of the rotation. An empty list gets STS_EMPTY with no scan.
// Reset clears the element count and the control state; cells are not reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dll_pkg::CMD_W-1:0]            cmd_i,
  input  logic signed [dll_pkg::DATA_W-1:0]    value_i,
  input  logic [dll_pkg::POS_W-1:0]            position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dll_pkg::STATUS_W-1:0]         status_o,
  output logic [dll_pkg::FIDX_W-1:0]           found_index_o,
  output logic signed [dll_pkg::DATA_W-1:0]    element_o,
  output logic [dll_pkg::LEN_W-1:0]            length_o,
  output logic                                 last_o
);

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > dll_pkg::POS_W) ? CW : dll_pkg::POS_W;

  dll_pkg::state_e   state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     step_q, step_d;
  logic signed [dll_pkg::DATA_W-1:0] key_q, key_d;
  logic              disp_q, disp_d;
  logic              found_q, found_d;
  logic [IW-1:0]     fidx_q, fidx_d;

  logic                                out_valid_q;
  logic [dll_pkg::STATUS_W-1:0]        status_q, status_d;
  logic [dll_pkg::FIDX_W-1:0]          fidx_out_q, fidx_out_d;
  logic signed [dll_pkg::DATA_W-1:0]   element_q, element_d;
  logic [dll_pkg::LEN_W-1:0]           length_q, length_d;
  logic                                last_q, last_d;
  logic                                out_load;

  dll_pkg::cell_op_t op;
  dll_pkg::cmd_e     cmd;
  logic              out_free;
  logic              accept;
  logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_pos, del_pos;
  logic [CW-1:0]     count_m1;
  logic              scan_last;
  logic              head_hit;
  logic signed [dll_pkg::DATA_W-1:0] cell_val [DEPTH];

  assign cmd      = dll_pkg::cmd_e'(cmd_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign count_m1 = count_q - CW'(1);
  assign scan_last = (CW'(step_q) == count_m1);
  assign head_hit = (cell_val[0] == key_q);

  always_comb begin
    case (cmd)
      dll_pkg::CMD_INS_FRONT: ins_pos = '0;
      dll_pkg::CMD_INS_BACK:  ins_pos = cnt_ext;
      default:                ins_pos = pos_ext;
    endcase
    case (cmd)
      dll_pkg::CMD_DEL_FRONT: del_pos = '0;
      dll_pkg::CMD_DEL_BACK:  del_pos = cnt_ext - CMP_W'(1);
      default:                del_pos = pos_ext;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    key_d      = key_q;
    disp_d     = disp_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    op.cmd     = dll_pkg::OP_HOLD;
    op.pos     = '0;
    op.wrap    = dll_pkg::IDX_W_MAX'(count_m1);
    op.value   = value_i;
    out_load   = 1'b0;
    status_d   = dll_pkg::STS_OK;
    fidx_out_d = '0;
    element_d  = '0;
    length_d   = dll_pkg::LEN_W'(count_q);
    last_d     = 1'b1;
    in_stall_o = 1'b1;
    case (state_q)
      dll_pkg::ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          out_load = 1'b1;
          case (cmd) inside
            dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_BACK, dll_pkg::CMD_INS_AT: begin
              if (ins_pos > cnt_ext) begin
                status_d = dll_pkg::STS_BADIDX;
              end else if (count_q == CW'(DEPTH)) begin
                status_d = dll_pkg::STS_FULL;
              end else begin
                op.cmd   = dll_pkg::OP_INSERT;
                op.pos   = dll_pkg::IDX_W_MAX'(ins_pos);
                count_d  = count_q + CW'(1);
                length_d = dll_pkg::LEN_W'(count_d);
              end
            end
            dll_pkg::CMD_DEL_FRONT, dll_pkg::CMD_DEL_BACK, dll_pkg::CMD_DEL_AT: begin
              if (count_q == '0) begin
                status_d = dll_pkg::STS_EMPTY;
              end else if (del_pos >= cnt_ext) begin
                status_d = dll_pkg::STS_BADIDX;
              end else begin
                op.cmd   = dll_pkg::OP_DELETE;
                op.pos   = dll_pkg::IDX_W_MAX'(del_pos);
                count_d  = count_m1;
                length_d = dll_pkg::LEN_W'(count_d);
              end
            end
            default: begin
              if (count_q == '0) begin
                status_d = dll_pkg::STS_EMPTY;
              end else begin
                out_load = 1'b0;
                state_d  = dll_pkg::ST_SCAN;
                step_d   = '0;
                key_d    = value_i;
                disp_d   = (cmd == dll_pkg::CMD_DISPLAY);
                found_d  = 1'b0;
                fidx_d   = '0;
              end
            end
          endcase
        end
      end
      dll_pkg::ST_SCAN: begin
        if (out_free) begin
          op.cmd = dll_pkg::OP_ROTATE;
          step_d = step_q + IW'(1);
          if (!found_q && head_hit) begin
            found_d = 1'b1;
            fidx_d  = step_q;
          end
          if (disp_q) begin
            out_load   = 1'b1;
            fidx_out_d = dll_pkg::FIDX_W'(step_q);
            element_d  = cell_val[0];
            last_d     = scan_last;
          end else if (scan_last) begin
            out_load = 1'b1;
            if (found_q) begin
              fidx_out_d = dll_pkg::FIDX_W'(fidx_q);
            end else if (head_hit) begin
              fidx_out_d = dll_pkg::FIDX_W'(step_q);
            end else begin
              status_d = dll_pkg::STS_NOFIND;
            end
          end
          if (scan_last) begin
            state_d = dll_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = dll_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dll_pkg::ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      disp_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      disp_q      <= disp_d;
      found_q     <= found_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    fidx_q <= fidx_d;
    if (out_load) begin
      status_q   <= status_d;
      fidx_out_q <= fidx_out_d;
      element_q  <= element_d;
      length_q   <= length_d;
      last_q     <= last_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [dll_pkg::DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = op.value;
    end else begin : g_mid_l
      assign left = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right = cell_val[g];
    end else begin : g_mid_r
      assign right = cell_val[g+1];
    end
    dll_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .left_i (left),
      .right_i(right),
      .head_i (cell_val[0]),
      .value_o(cell_val[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = fidx_out_q;
  assign element_o     = element_q;
  assign length_o      = length_q;
  assign last_o        = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
         count_q == $past(count_q) - CW'(1)))
    else $error("element count moved by more than one");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dll_pkg::ST_SCAN |-> (CW'(step_q) < count_q))
    else $error("scan step past list end");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dll_pkg::ST_SCAN |=> $stable(count_q))
    else $error("element count changed during scan");

  a_no_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dll_pkg::ST_SCAN && !scan_last |=> !accept)
    else $error("word accepted in the middle of a scan");

endmodule

@@ hw/rtl/dll_cell.sv @@
// ----------------------------------------------------------------------------
// dll_cell
// One list cell: holds one element and, on insert, delete or rotate, takes
// a neighbor's, the new or the head element, as the broadcast op word selects.
// ----------------------------------------------------------------------------
module dll_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  dll_pkg::cell_op_t                   op_i,
  input  logic signed [dll_pkg::DATA_W-1:0]   left_i,
  input  logic signed [dll_pkg::DATA_W-1:0]   right_i,
  input  logic signed [dll_pkg::DATA_W-1:0]   head_i,
  output logic signed [dll_pkg::DATA_W-1:0]   value_o
);

  localparam logic [dll_pkg::IDX_W_MAX-1:0] MyIdx = dll_pkg::IDX_W_MAX'(IDX);

  logic signed [dll_pkg::DATA_W-1:0] value_q;
  logic signed [dll_pkg::DATA_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    case (op_i.cmd)
      dll_pkg::OP_INSERT: begin
        if (MyIdx > op_i.pos) begin
          value_d = left_i;
        end else if (MyIdx == op_i.pos) begin
          value_d = op_i.value;
        end
      end
      dll_pkg::OP_DELETE: begin
        if (MyIdx >= op_i.pos) begin
          value_d = right_i;
        end
      end
      dll_pkg::OP_ROTATE: begin
        if (MyIdx == op_i.wrap) begin
          value_d = head_i;
        end else if (MyIdx < op_i.wrap) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
